[hdl/kcr_pkg.sv]
// ----------------------------------------------------------------------------
// kcr_pkg
// Shared constants and types of the keyframe Catmull-Rom evaluator.
// ----------------------------------------------------------------------------
package kcr_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_AW   = $clog2(MAX_KEYS);
  localparam int CNT_W    = KEY_AW + 1;

  // fixed-point widths
  localparam int PT_W   = 32;
  localparam int NUM_W  = 48;
  localparam int U_W    = 17;
  localparam int U2_W   = 2 * U_W;
  localparam int U3_W   = 3 * U_W;
  localparam int N_W    = 54;
  localparam int W_W    = 28;
  localparam int PROD_W = PT_W + W_W;
  localparam int ACC_W  = 64;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_EVAL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_EVALUATED = 3'd0,
    ST_NO_SEG    = 3'd1,
    ST_STORED    = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

endpackage

[hdl/kcr_ram.sv]
// ----------------------------------------------------------------------------
// kcr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/keyframe_catmull_rom_evaluator.sv]
// ----------------------------------------------------------------------------
// keyframe_catmull_rom_evaluator
// Keypoint table with Catmull-Rom evaluation at a query time.
// ----------------------------------------------------------------------------
// Add and clear transactions: the result passes through S_DONE into the output register.
// Evaluate: a segment scan (one key per cycle on the time RAM port), a bit-serial
// divide, then u^2, u^3, the weights and the weighted sums through one multiplier.
// One transaction is worked on at a time; a new one is taken while the result
// still waits in the output register.
// Reset clears the key count and control state; RAM contents are not cleared.
module keyframe_catmull_rom_evaluator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [31:0] time_req, [63:32] point_x, [95:64] point_y, [127:96] point_z
  input  logic [127:0]  s_axis_tdata,
  // [1:0] op
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [31:0] curve_x, [63:32] curve_y, [95:64] curve_z
  output logic [95:0]   m_axis_tdata,
  // [2:0] status
  output logic [2:0]    m_axis_tuser
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SCAN = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_SQR  = 9'b000001000,
    S_CUBE = 9'b000010000,
    S_WGT  = 9'b000100000,
    S_MUL  = 9'b001000000,
    S_ACC  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [kcr_pkg::CNT_W-1:0]  cnt_q;
  logic [kcr_pkg::KEY_AW-1:0] idx_q, pend_idx_q, seg_q;
  logic                       pend_v_q;
  logic [31:0]                t_q, prev_t_q, tk_q, tk1_q;
  logic [kcr_pkg::NUM_W-1:0]  num_q;
  logic [31:0]                rem_q;
  logic [kcr_pkg::U_W-1:0]    u_q;
  logic [5:0]                 div_cnt_q;
  logic [95:0]                p_q [4];
  logic [kcr_pkg::U2_W-1:0]   u2_q;
  logic [kcr_pkg::U3_W-1:0]   u3_q;
  logic signed [kcr_pkg::W_W-1:0]    w_q [4];
  logic signed [kcr_pkg::PROD_W-1:0] prod_q;
  logic signed [kcr_pkg::ACC_W-1:0]  acc_q;
  logic [1:0]                 c_q, j_q;
  logic [31:0]                res_q [3];
  kcr_pkg::status_e           st_q;
  logic                       out_valid_q;
  kcr_pkg::status_e           out_status_q;
  logic [95:0]                out_data_q;

  // input fields
  kcr_pkg::op_e op_in;
  logic [31:0]  t_in;
  assign op_in = kcr_pkg::op_e'(s_axis_tuser);
  assign t_in  = s_axis_tdata[31:0];

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // table writes happen on an accepted add with room left
  logic room, wr_en;
  assign room  = (cnt_q < kcr_pkg::CNT_W'(kcr_pkg::MAX_KEYS));
  assign wr_en = accept && (op_in == kcr_pkg::OP_ADD) && room;

  logic [31:0] t_rdata;
  logic [95:0] p_rdata;
  logic [kcr_pkg::KEY_AW-1:0] p_raddr;
  assign p_raddr = seg_q - kcr_pkg::KEY_AW'(1) + kcr_pkg::KEY_AW'(div_cnt_q[1:0]);

  kcr_ram #(.WIDTH(32), .DEPTH(kcr_pkg::MAX_KEYS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[kcr_pkg::KEY_AW-1:0]),
    .wdata_i (t_in),
    .raddr_i (idx_q),
    .rdata_o (t_rdata)
  );

  kcr_ram #(.WIDTH(96), .DEPTH(kcr_pkg::MAX_KEYS)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[kcr_pkg::KEY_AW-1:0]),
    .wdata_i (s_axis_tdata[127:32]),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // segment match on the key pair now at hand
  logic seg_hit, scan_last;
  assign seg_hit   = (prev_t_q < t_q) && (t_rdata >= t_q);
  assign scan_last = ({1'b0, pend_idx_q} == cnt_q - kcr_pkg::CNT_W'(2));

  // restoring divide step
  logic [32:0] rem_sh, rem_sub;
  logic        q_bit;
  assign rem_sh  = {rem_q, num_q[kcr_pkg::NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, tk1_q - tk_q};
  assign q_bit   = !rem_sub[32];

  // weights from u, u^2, u^3, scaled by 2*S^3
  logic signed [kcr_pkg::N_W-1:0] u3e, u2s, us2, s3;
  logic signed [kcr_pkg::N_W-1:0] n_w [4];
  logic signed [kcr_pkg::N_W-1:0] n_r [4];
  always_comb begin
    u3e = $signed(kcr_pkg::N_W'(u3_q));
    u2s = $signed(kcr_pkg::N_W'(u2_q) << 16);
    us2 = $signed(kcr_pkg::N_W'(u_q) << 32);
    s3  = $signed(kcr_pkg::N_W'(1) << 49);
    n_w[0] = (u2s <<< 1) - u3e - us2;
    n_w[1] = u3e + (u3e <<< 1) - (u2s <<< 2) - u2s + s3;
    n_w[2] = (u2s <<< 2) + us2 - u3e - (u3e <<< 1);
    n_w[3] = u3e - u2s;
    for (int i = 0; i < 4; i++) begin
      n_r[i] = (n_w[i] + $signed(kcr_pkg::N_W'(1) << 24)) >>> 25;
    end
  end

  // multiplier operand and accumulation
  logic signed [31:0]               p_sel;
  logic signed [kcr_pkg::ACC_W-1:0] acc_sum, acc_rnd;
  logic [31:0]                      sat_val;
  always_comb begin
    p_sel   = $signed(p_q[j_q][c_q*32 +: 32]);
    acc_sum = acc_q + kcr_pkg::ACC_W'(prod_q);
    acc_rnd = (acc_sum + $signed(kcr_pkg::ACC_W'(1) << 23)) >>> 24;
    if (acc_rnd > $signed(kcr_pkg::ACC_W'(32'h7fffffff))) begin
      sat_val = 32'h7fffffff;
    end else if (acc_rnd < -$signed(kcr_pkg::ACC_W'(33'h80000000))) begin
      sat_val = 32'h80000000;
    end else begin
      sat_val = acc_rnd[31:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_in)
            kcr_pkg::OP_ADD, kcr_pkg::OP_CLEAR: state_d = S_DONE;
            kcr_pkg::OP_EVAL: begin
              if (cnt_q < kcr_pkg::CNT_W'(4)) state_d = S_DONE;
              else                            state_d = S_SCAN;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (pend_v_q && pend_idx_q != kcr_pkg::KEY_AW'(1)) begin
          if (seg_hit)        state_d = S_DIV;
          else if (scan_last) state_d = S_DONE;
        end
      end
      S_DIV:  if (div_cnt_q == 6'(kcr_pkg::NUM_W - 1)) state_d = S_SQR;
      S_SQR:  state_d = S_CUBE;
      S_CUBE: state_d = S_WGT;
      S_WGT:  state_d = S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC: begin
        if (j_q == 2'd3 && c_q == 2'd2) state_d = S_DONE;
        else                            state_d = S_MUL;
      end
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pend_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        cnt_q <= cnt_q + kcr_pkg::CNT_W'(1);
      end else if (accept && op_in == kcr_pkg::OP_CLEAR) begin
        cnt_q <= '0;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      pend_v_q <= (state_q == S_SCAN);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        t_q   <= t_in;
        idx_q <= kcr_pkg::KEY_AW'(1);
        for (int i = 0; i < 3; i++) res_q[i] <= '0;
        if (op_in == kcr_pkg::OP_ADD) begin
          st_q <= room ? kcr_pkg::ST_STORED : kcr_pkg::ST_FULL;
        end else if (op_in == kcr_pkg::OP_CLEAR) begin
          st_q <= kcr_pkg::ST_CLEARED;
        end else begin
          st_q <= kcr_pkg::ST_NO_SEG;
        end
      end
      S_SCAN: begin
        idx_q      <= idx_q + kcr_pkg::KEY_AW'(1);
        pend_idx_q <= idx_q;
        if (pend_v_q) begin
          prev_t_q <= t_rdata;
          if (pend_idx_q != kcr_pkg::KEY_AW'(1) && seg_hit) begin
            seg_q     <= pend_idx_q - kcr_pkg::KEY_AW'(1);
            tk_q      <= prev_t_q;
            tk1_q     <= t_rdata;
            num_q     <= {t_q - prev_t_q, 16'h0000};
            rem_q     <= '0;
            div_cnt_q <= '0;
          end
        end
      end
      S_DIV: begin
        num_q     <= num_q << 1;
        rem_q     <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
        u_q       <= {u_q[kcr_pkg::U_W-2:0], q_bit};
        div_cnt_q <= div_cnt_q + 6'd1;
        // fetch the four neighbor points while dividing
        if (div_cnt_q >= 6'd1 && div_cnt_q <= 6'd4) begin
          p_q[2'(div_cnt_q - 6'd1)] <= p_rdata;
        end
      end
      S_SQR:  u2_q <= kcr_pkg::U2_W'(u_q) * kcr_pkg::U2_W'(u_q);
      S_CUBE: u3_q <= kcr_pkg::U3_W'(u2_q) * kcr_pkg::U3_W'(u_q);
      S_WGT: begin
        for (int i = 0; i < 4; i++) w_q[i] <= n_r[i][kcr_pkg::W_W-1:0];
        acc_q <= '0;
        c_q   <= '0;
        j_q   <= '0;
        st_q  <= kcr_pkg::ST_EVALUATED;
      end
      S_MUL:  prod_q <= kcr_pkg::PROD_W'(p_sel) * kcr_pkg::PROD_W'(w_q[j_q]);
      S_ACC: begin
        if (j_q == 2'd3) begin
          res_q[c_q] <= sat_val;
          acc_q      <= '0;
          c_q        <= c_q + 2'd1;
        end else begin
          acc_q <= acc_sum;
        end
        j_q <= j_q + 2'd1;
      end
      S_DONE: begin
        if (out_free) begin
          out_status_q <= st_q;
          out_data_q   <= {res_q[2], res_q[1], res_q[0]};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule
